### design/tre_pkg.sv
// Shared types, constants and command codes of the text register engine.
`default_nettype none

package tre_pkg;

  // Defaults and fixed field widths
  localparam int ALPHA_CHARS_DEF     = 31;
  localparam int REAL_CHARS_PER_WORD = 6;
  localparam int CMD_W               = 4;
  localparam int COUNT_W             = 8;
  localparam int DATA_W              = 64;
  localparam int LEN_W               = 5;
  localparam int CFG_IDX_W           = 1;
  localparam int CFG_DATA_W          = 7;
  localparam int WB_W                = 7;
  localparam int STEP_W              = 8;
  localparam int BYTE_IDX_W          = 3;
  localparam int NPW_W               = 4;

  localparam logic [7:0]      SPACE_CHAR    = 8'h20;
  localparam logic [WB_W-1:0] WORD_BITS_RST = 7'd64;

  // Command codes carried on cmd
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 4'd0,
    CMD_APPEND  = 4'd1,
    CMD_APPEND3 = 4'd2,
    CMD_SHL     = 4'd3,
    CMD_ROTL    = 4'd4,
    CMD_SHR     = 4'd5,
    CMD_ROTR    = 4'd6,
    CMD_LEN     = 4'd7,
    CMD_TAKE    = 4'd8,
    CMD_FROMVAL = 4'd9,
    CMD_PACK    = 4'd10,
    CMD_UNPACK  = 4'd11
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INT_MODE  = 1'b0,
    CFG_WORD_BITS = 1'b1
  } cfg_reg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } tre_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [STEP_W-1:0] steps;
    logic              stop;
  } tre_stat_t;

endpackage

`default_nettype wire

### design/tre_ctrl.sv
// Controller of the text register engine: request sequencing and step counting.
`default_nettype none

module tre_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire tre_pkg::tre_stat_t stat,
  output tre_pkg::tre_ctl_t      ctl
);
  import tre_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic              out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          cnt_next   = stat.steps;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (cnt == '0 || stat.stop) begin
          if (out_free) begin
            ctl.emit   = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_HOLD;
          end
        end else begin
          ctl.step = 1'b1;
          cnt_next = cnt - 1'b1;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State, step counter and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= ctl.emit | (out_valid & ~out_ready);
    end
  end

endmodule

`default_nettype wire

### design/tre_dp.sv
// Datapath of the text register engine: character store, count, config and result.
`default_nettype none

module tre_dp #(
  parameter int ALPHA_CHARS = tre_pkg::ALPHA_CHARS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [tre_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tre_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [tre_pkg::CMD_W-1:0]     cmd,
  input  wire logic [tre_pkg::COUNT_W-1:0]   count,
  input  wire logic [tre_pkg::DATA_W-1:0]    operand,
  input  wire tre_pkg::tre_ctl_t             ctl,
  output tre_pkg::tre_stat_t                 stat,
  output logic [tre_pkg::DATA_W-1:0]         value,
  output logic [tre_pkg::LEN_W-1:0]          length
);
  import tre_pkg::*;

  localparam int IW = $clog2(ALPHA_CHARS);
  localparam int CW = $clog2(ALPHA_CHARS + 1);
  localparam logic [CW-1:0]     FULL_CNT   = CW'(ALPHA_CHARS);
  localparam logic [STEP_W-1:0] ALPHA_STEP = STEP_W'(ALPHA_CHARS);

  logic [7:0]            store [ALPHA_CHARS];
  logic [7:0]            store_next [ALPHA_CHARS];
  logic [7:0]            sl [ALPHA_CHARS];
  logic [CW-1:0]         ccount, ccount_next, cnt_m1, wpos;
  logic [CMD_W-1:0]      op;
  logic [DATA_W-1:0]     opnd;
  logic [DATA_W-1:0]     acc, acc_next;
  logic [IW-1:0]         rd_idx, rd_idx_next, rd_addr;
  logic [BYTE_IDX_W-1:0] byte_idx, byte_idx_next;
  logic [7:0]            rd_data, raw_byte, mag_byte, cur_byte;
  logic                  int_mode;
  logic [WB_W-1:0]       word_bits;
  logic [NPW_W-1:0]      npw, sig_bytes, unpack_k;
  logic [STEP_W-1:0]     c8, n8;
  logic                  full, empty;

  assign full   = (ccount == FULL_CNT);
  assign empty  = (ccount == '0);
  assign cnt_m1 = ccount - 1'b1;
  assign wpos   = full ? FULL_CNT - 1'b1 : ccount;

  // Characters per word
  assign npw = int_mode ? word_bits[WB_W-1:3] : NPW_W'(REAL_CHARS_PER_WORD);

  // Significant bytes of the incoming word, capped at characters per word
  always_comb begin
    sig_bytes = '0;
    for (int i = 0; i < 8; i++) begin
      if (operand[8*i +: 8] != 8'd0) sig_bytes = NPW_W'(i + 1);
    end
    unpack_k = (sig_bytes < npw) ? sig_bytes : npw;
  end

  // Steps for the input request; append3 and unpack stop early on a zero byte
  assign c8 = STEP_W'(ccount);
  assign n8 = STEP_W'(npw);
  always_comb begin
    stat.stop = (op == CMD_APPEND3 || op == CMD_UNPACK) && (cur_byte == 8'd0);
    case (cmd)
      CMD_CLEAR, CMD_APPEND, CMD_FROMVAL, CMD_LEN, CMD_TAKE: stat.steps = STEP_W'(1);
      CMD_APPEND3:        stat.steps = STEP_W'(3);
      CMD_SHL, CMD_SHR:   stat.steps = (count > ALPHA_STEP) ? ALPHA_STEP : count;
      CMD_ROTL, CMD_ROTR: stat.steps = count;
      CMD_PACK:           stat.steps = (c8 < n8) ? c8 : n8;
      CMD_UNPACK:         stat.steps = STEP_W'(unpack_k);
      default:            stat.steps = '0;
    endcase
  end

  // Current source byte; magnitude low byte for signed values
  assign raw_byte = opnd[{byte_idx, 3'b000} +: 8];
  assign mag_byte = opnd[DATA_W-1] ? (~opnd[7:0]) + 8'd1 : opnd[7:0];
  assign cur_byte = (op == CMD_FROMVAL) ? mag_byte : raw_byte;

  // Single read port: last held character for rotate right, else pack index
  assign rd_addr = (op == CMD_ROTR) ? cnt_m1[IW-1:0] : rd_idx;
  assign rd_data = store[rd_addr];

  // Store shifted left by one with zero fill
  always_comb begin
    for (int i = 0; i < ALPHA_CHARS; i++) begin
      sl[i] = (i < ALPHA_CHARS - 1) ? store[(i + 1) % ALPHA_CHARS] : 8'd0;
    end
  end

  // Load of a new request, or one step of the current command
  always_comb begin
    store_next    = store;
    ccount_next   = ccount;
    acc_next      = acc;
    rd_idx_next   = rd_idx;
    byte_idx_next = byte_idx;
    if (ctl.load) begin
      acc_next      = '0;
      rd_idx_next   = '0;
      byte_idx_next = (cmd == CMD_UNPACK) ? BYTE_IDX_W'(unpack_k - 1'b1) : '0;
    end else if (ctl.step) begin
      case (op)
        CMD_CLEAR: begin
          for (int i = 0; i < ALPHA_CHARS; i++) store_next[i] = 8'd0;
          ccount_next = '0;
        end
        CMD_APPEND, CMD_FROMVAL, CMD_APPEND3, CMD_UNPACK: begin
          // drop oldest when full, then store a nonzero byte
          for (int i = 0; i < ALPHA_CHARS; i++) begin
            store_next[i] = full ? sl[i] : store[i];
            if (cur_byte != 8'd0 && CW'(i) == wpos) store_next[i] = cur_byte;
          end
          ccount_next   = (full ? cnt_m1 : ccount) + CW'(cur_byte != 8'd0);
          byte_idx_next = (op == CMD_UNPACK) ? byte_idx - 1'b1 : byte_idx + 1'b1;
        end
        CMD_SHL, CMD_TAKE: begin
          if (op == CMD_TAKE) acc_next = DATA_W'(store[0]);
          store_next  = sl;
          ccount_next = empty ? ccount : cnt_m1;
        end
        CMD_ROTL: begin
          if (!empty) begin
            for (int i = 0; i < ALPHA_CHARS; i++) begin
              store_next[i] = (CW'(i) == cnt_m1) ? store[0] : sl[i];
            end
          end
        end
        CMD_SHR: begin
          store_next[0] = SPACE_CHAR;
          for (int i = 1; i < ALPHA_CHARS; i++) store_next[i] = store[i-1];
          ccount_next = full ? ccount : ccount + 1'b1;
        end
        CMD_ROTR: begin
          if (!empty) begin
            store_next[0] = rd_data;
            for (int i = 1; i < ALPHA_CHARS; i++) begin
              store_next[i] = (CW'(i) < ccount) ? store[i-1] : store[i];
            end
          end
        end
        CMD_LEN: acc_next = DATA_W'(ccount);
        CMD_PACK: begin
          acc_next    = {acc[DATA_W-9:0], rd_data};
          rd_idx_next = rd_idx + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Character store and count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ALPHA_CHARS; i++) store[i] <= 8'd0;
      ccount <= '0;
    end else begin
      store  <= store_next;
      ccount <= ccount_next;
    end
  end

  // Working registers of the current request
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op   <= cmd;
      opnd <= operand;
    end
    acc      <= acc_next;
    rd_idx   <= rd_idx_next;
    byte_idx <= byte_idx_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      value  <= acc;
      length <= LEN_W'(ccount);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      int_mode  <= 1'b0;
      word_bits <= WORD_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INT_MODE:  int_mode  <= cfg_data[0];
        CFG_WORD_BITS: word_bits <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/text_register_engine.sv
// Top level of the text register engine: controller plus datapath.
//
// A calculator character register of ALPHA_CHARS bytes with a current length.
// Input channel (in_valid/in_ready) carries one request: cmd, count, operand.
// Output channel (out_valid/out_ready) returns exactly one result per request:
// value (length, taken character or packed word, else zero) and length.
// Config writes (cfg_we, cfg_index, cfg_data) are registered directly, no wait.
// A request runs S steps and then finishes by emitting the result; out_valid
// is registered from that and in_ready returns with it, so a new request is
// taken only once the last one is done. S is 1 for clear, append, fromval,
// len and take, 3 for append3 (less on a zero byte), min(count, ALPHA_CHARS)
// for shl/shr, count for rotates, min(length, chars per word) for pack, the
// used bytes capped at chars per word for unpack (less on a zero byte), 0 for
// unknown codes. Each shift or rotate step moves the whole store by one
// character. A finished result sits in the output register, so the next
// request is taken while it waits; if the receiver still stalls when another
// result is ready, the engine holds. Reset (rst, synchronous) empties the
// register, zeroes every character and restores int_mode = 0, word_bits = 64.
`default_nettype none

module text_register_engine #(
  parameter int ALPHA_CHARS = tre_pkg::ALPHA_CHARS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [tre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tre_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [tre_pkg::CMD_W-1:0]      cmd,
  input  wire logic [tre_pkg::COUNT_W-1:0]    count,
  input  wire logic [tre_pkg::DATA_W-1:0]     operand,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [tre_pkg::DATA_W-1:0]          value,
  output logic [tre_pkg::LEN_W-1:0]           length
);
  import tre_pkg::*;

  tre_ctl_t  ctl;
  tre_stat_t stat;

  // Request sequencing
  tre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // Store, config and result registers
  tre_dp #(
    .ALPHA_CHARS (ALPHA_CHARS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .count     (count),
    .operand   (operand),
    .ctl       (ctl),
    .stat      (stat),
    .value     (value),
    .length    (length)
  );

endmodule

`default_nettype wire

### design/tre_checker.sv
// Port-level checks of the text register engine and their bind.
`default_nettype none

module tre_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic [tre_pkg::CMD_W-1:0]      cmd,
  input wire logic [tre_pkg::COUNT_W-1:0]    count,
  input wire logic [tre_pkg::DATA_W-1:0]     operand,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [tre_pkg::DATA_W-1:0]     value,
  input wire logic [tre_pkg::LEN_W-1:0]      length
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(length))
    else $error("result changed while stalled");

  // Waiting request holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=>
      in_valid && $stable(cmd) && $stable(count) && $stable(operand))
    else $error("request changed while waiting");

  // Reset leaves no result pending and the input open
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("engine not idle after reset");

  // An accepted request leaves the input not ready in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a request");

  // A new result only appears when the input was busy in the cycle before
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without preceding work");

endmodule

bind text_register_engine tre_checker u_tre_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .cmd       (cmd),
  .count     (count),
  .operand   (operand),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .value     (value),
  .length    (length)
);

`default_nettype wire

### dv/text_register_engine_checker.sv
// Checker for the text register engine: tracks the character register and compares results.
`timescale 1ns / 1ps

module text_register_engine_checker #(
  parameter int ALPHA_CHARS = tre_pkg::ALPHA_CHARS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [tre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tre_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [tre_pkg::CMD_W-1:0]      cmd,
  input  logic [tre_pkg::COUNT_W-1:0]    count,
  input  logic [tre_pkg::DATA_W-1:0]     operand,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [tre_pkg::DATA_W-1:0]     value,
  input  logic [tre_pkg::LEN_W-1:0]      length,
  output int                             errors,
  output int                             outstanding
);
  import tre_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic [LEN_W-1:0]  len;
  } reg_result_t;

  // Predicted register contents and configuration
  logic [7:0]      held_chars [ALPHA_CHARS];
  int              held_len;
  logic            int_mode_q;
  logic [WB_W-1:0] word_bits_q;

  reg_result_t     pending_results [$];
  int              fail_count;

  initial fail_count = 0;

  function automatic int word_chars();
    return int_mode_q ? int'(word_bits_q) / 8 : REAL_CHARS_PER_WORD;
  endfunction

  task automatic clear_chars();
    for (int i = 0; i < ALPHA_CHARS; i++) held_chars[i] = 8'h00;
    held_len = 0;
  endtask

  // Remove the first character; slots past the length stay zero
  task automatic drop_front_char();
    if (held_len == 0) return;
    for (int i = 1; i < held_len; i++) held_chars[i-1] = held_chars[i];
    held_len--;
    held_chars[held_len] = 8'h00;
  endtask

  // Full register loses its oldest char first; a zero byte is never stored
  task automatic append_char(input logic [7:0] c);
    if (held_len >= ALPHA_CHARS) drop_front_char();
    if (c != 8'h00) begin
      held_chars[held_len] = c;
      held_len++;
    end
  endtask

  task automatic apply_request(input logic [CMD_W-1:0] c, input logic [COUNT_W-1:0] n,
                               input logic [DATA_W-1:0] op, output reg_result_t r);
    logic [DATA_W-1:0] val;
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] rest;
    logic [7:0]        end_char;
    logic [7:0]        word_bytes [16];
    int                k;
    int                lim;
    val = '0;
    case (c)
      CMD_CLEAR: clear_chars();
      CMD_APPEND: append_char(op[7:0]);
      CMD_APPEND3: begin
        for (int i = 0; i < 3; i++) begin
          if (op[8*i +: 8] == 8'h00) break;
          append_char(op[8*i +: 8]);
        end
      end
      CMD_SHL: repeat (n) drop_front_char();
      CMD_ROTL: begin
        repeat (n) begin
          if (held_len != 0) begin
            end_char = held_chars[0];
            drop_front_char();
            held_chars[held_len] = end_char;
            held_len++;
          end
        end
      end
      CMD_SHR: begin
        // whole store shifts; last char falls off when full
        repeat (n) begin
          for (int i = ALPHA_CHARS - 1; i > 0; i--) held_chars[i] = held_chars[i-1];
          held_chars[0] = SPACE_CHAR;
          if (held_len < ALPHA_CHARS) held_len++;
        end
      end
      CMD_ROTR: begin
        repeat (n) begin
          if (held_len != 0) begin
            end_char = held_chars[held_len-1];
            for (int i = held_len - 1; i > 0; i--) held_chars[i] = held_chars[i-1];
            held_chars[0] = end_char;
          end
        end
      end
      CMD_LEN: val = DATA_W'(held_len);
      CMD_TAKE: begin
        val = (held_len != 0) ? DATA_W'(held_chars[0]) : '0;
        drop_front_char();
      end
      CMD_FROMVAL: begin
        mag = op[DATA_W-1] ? (DATA_W'(0) - op) : op;
        append_char(mag[7:0]);
      end
      CMD_PACK: begin
        lim = word_chars();
        for (int i = 0; i < held_len && i < lim; i++) val = {val[DATA_W-9:0], held_chars[i]};
      end
      CMD_UNPACK: begin
        // collect low bytes until the word runs out, append high byte first
        lim = word_chars();
        rest = op;
        k = 0;
        while (rest != '0 && k < lim && k < 16) begin
          word_bytes[k] = rest[7:0];
          k++;
          rest = rest >> 8;
        end
        while (k > 0) begin
          k--;
          if (word_bytes[k] == 8'h00) break;
          append_char(word_bytes[k]);
        end
      end
      default: ;
    endcase
    r.val = val;
    r.len = LEN_W'(held_len);
  endtask

  // Watch config writes, requests and results on every edge
  always @(posedge clk) begin : watch
    reg_result_t want;
    if (rst) begin
      clear_chars();
      int_mode_q  = 1'b0;
      word_bits_q = WORD_BITS_RST;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_INT_MODE:  int_mode_q = cfg_data[0];
          CFG_WORD_BITS: word_bits_q = cfg_data[WB_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        apply_request(cmd, count, operand, want);
        pending_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request pending: value 0x%0h length %0d", value, length);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (value !== want.val) begin
            $error("value: expected 0x%0h, actual 0x%0h", want.val, value);
            fail_count++;
          end
          if (length !== want.len) begin
            $error("length: expected %0d, actual %0d", want.len, length);
            fail_count++;
          end
        end
      end
    end
    outstanding <= pending_results.size();
    errors      <= fail_count;
  end

endmodule

### dv/text_register_engine_tb.sv
// Testbench top for the text register engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module text_register_engine_tb;
  import tre_pkg::*;

  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_W'(CMD_UNPACK + 1);
  localparam logic [CMD_W-1:0] CMD_CODE_MAX     = {CMD_W{1'b1}};
  localparam int SEG_REQUESTS = 255;
  localparam int SETTLE_CYCLES = 300;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      cmd       = '0;
  logic [COUNT_W-1:0]    count     = '0;
  logic [DATA_W-1:0]     operand   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DATA_W-1:0]     value;
  logic [LEN_W-1:0]      length;

  int errors;
  int outstanding;
  int send_idle_pct = 35;
  int recv_idle_pct = 67;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_register_engine u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .count(count), .operand(operand),
    .out_valid(out_valid), .out_ready(out_ready),
    .value(value), .length(length)
  );

  text_register_engine_checker u_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .count(count), .operand(operand),
    .out_valid(out_valid), .out_ready(out_ready),
    .value(value), .length(length),
    .errors(errors), .outstanding(outstanding)
  );

  // Receiver stalls at random
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else     out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Present one request and hold it until taken; valid stays high for a
  // back-to-back request and drops only for an idle gap
  task automatic send_request(input logic [CMD_W-1:0] c, input logic [COUNT_W-1:0] n,
                              input logic [DATA_W-1:0] op);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    count    <= n;
    operand  <= op;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait for every result to come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  // Both registers, one after the other, while the engine is idle
  task automatic write_config(input logic mode, input logic [WB_W-1:0] wbits);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_INT_MODE;
    cfg_data  <= {6'($urandom), mode};
    @(posedge clk);
    cfg_index <= CFG_WORD_BITS;
    cfg_data  <= wbits;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Weighted request mix; appends dominate so the register often runs full
  task automatic send_random_request();
    int                 pick;
    int                 nbytes;
    logic [CMD_W-1:0]   c;
    logic [COUNT_W-1:0] n;
    logic [DATA_W-1:0]  op;
    pick = $urandom_range(99);
    n    = COUNT_W'($urandom);
    op   = {$urandom, $urandom};
    if (pick < 22) begin
      c = CMD_APPEND;
      if ($urandom_range(19) == 0) op[7:0] = 8'h00;
    end else if (pick < 34) begin
      c = CMD_APPEND3;
      for (int j = 0; j < 3; j++) if ($urandom_range(7) == 0) op[8*j +: 8] = 8'h00;
    end else if (pick < 66) begin
      if (pick < 42)      c = CMD_SHL;
      else if (pick < 50) c = CMD_ROTL;
      else if (pick < 58) c = CMD_SHR;
      else                c = CMD_ROTR;
      // mostly short walks, now and then a long one
      pick = $urandom_range(99);
      if (pick < 75)      n = COUNT_W'($urandom_range(8));
      else if (pick < 97) n = COUNT_W'($urandom_range(40, 9));
      else                n = COUNT_W'($urandom_range(255, 41));
    end else if (pick < 70) begin
      c = CMD_LEN;
    end else if (pick < 76) begin
      c = CMD_TAKE;
    end else if (pick < 82) begin
      c = CMD_FROMVAL;
      case ($urandom_range(3))
        0: ;
        1: op = DATA_W'($urandom_range(600)) - DATA_W'(300);
        2: op = {1'b1, {(DATA_W-1){1'b0}}};
        default: op[DATA_W-1] = 1'b1;
      endcase
    end else if (pick < 88) begin
      c = CMD_PACK;
    end else if (pick < 94) begin
      c = CMD_UNPACK;
      nbytes = $urandom_range(8);
      if (nbytes < 8) op = op & ~({DATA_W{1'b1}} << (8 * nbytes));
      if ($urandom_range(3) == 0) begin
        nbytes = $urandom_range(7);
        op[8*nbytes +: 8] = 8'h00;
      end
    end else if (pick < 96) begin
      c = CMD_CLEAR;
    end else begin
      c = CMD_CODE_MAX - CMD_W'($urandom_range(CMD_CODE_MAX - CMD_FIRST_UNUSED));
    end
    send_request(c, n, op);
  endtask

  // Stimulus
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty register, append rules, full register, long walks
    send_request(CMD_LEN, 8'd0, '0);
    send_request(CMD_TAKE, 8'd0, '0);
    send_request(CMD_SHL, 8'd3, '0);
    send_request(CMD_ROTL, 8'd5, '0);
    send_request(CMD_ROTR, 8'd255, '1);
    send_request(CMD_APPEND, 8'd0, 64'hffff_ffff_ffff_ff41);
    send_request(CMD_APPEND, 8'd0, 64'h0);
    send_request(CMD_APPEND, 8'd255, 64'h0000_0000_0000_00ff);
    send_request(CMD_APPEND3, 8'd0, 64'h0000_0000_0043_4241);
    send_request(CMD_APPEND3, 8'd0, 64'h0000_0000_0044_0042);
    send_request(CMD_FROMVAL, 8'd0, 64'h8000_0000_0000_0000);
    send_request(CMD_FROMVAL, 8'd0, 64'hffff_ffff_ffff_ffbf);
    send_request(CMD_FROMVAL, 8'd0, 64'h7fff_ffff_ffff_ffff);
    send_request(CMD_PACK, 8'd0, '0);
    send_request(CMD_UNPACK, 8'd0, 64'h0000_0000_0061_6263);
    send_request(CMD_UNPACK, 8'd0, '1);
    send_request(CMD_UNPACK, 8'd0, '0);
    send_request(CMD_SHR, 8'd40, '0);
    send_request(CMD_APPEND, 8'd0, 64'h5a);
    send_request(CMD_APPEND, 8'd0, 64'h0);
    send_request(CMD_ROTL, 8'd255, '0);
    send_request(CMD_ROTR, 8'd7, '0);
    send_request(CMD_ROTL, 8'd0, '0);
    send_request(CMD_PACK, 8'd0, '0);
    send_request(CMD_SHL, 8'd255, '0);
    send_request(CMD_FIRST_UNUSED, 8'd255, '1);
    send_request(CMD_CODE_MAX, 8'd0, '0);
    send_request(CMD_CLEAR, 8'd0, '0);

    // random segments, each under its own word size; idle pattern changes every two segments
    for (int seg = 0; seg < 6; seg++) begin
      wait_drained();
      case (seg)
        0: write_config(1'b0, 7'd0);
        1: write_config(1'b1, 7'd64);
        2: write_config(1'b1, 7'd8);
        3: write_config(1'b1, WB_W'($urandom_range(7)));
        4: write_config(1'b1, 7'd127);
        default: write_config(1'b1, WB_W'($urandom_range(63, 9)));
      endcase
      if (seg < 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 67;
      end else if (seg < 4) begin
        send_idle_pct = 67;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int i = 0; i < SEG_REQUESTS; i++) begin
        // pause mid-segment until the engine has answered everything
        if (i == SEG_REQUESTS / 2) wait_drained();
        send_random_request();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("text_register_engine regression: pass");
    end else begin
      $display("text_register_engine regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #25_000_000;
    $display("text_register_engine regression: fail");
    $finish;
  end

endmodule

### files.f
design/tre_pkg.sv
design/tre_ctrl.sv
design/tre_dp.sv
design/text_register_engine.sv
design/tre_checker.sv
dv/text_register_engine_checker.sv
dv/text_register_engine_tb.sv
